### hw/rtl/intensity_edge_point_detector_defines.svh
// assertion macros of the edge point detector checker
`ifndef INTENSITY_EDGE_POINT_DETECTOR_DEFINES_SVH
`define INTENSITY_EDGE_POINT_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define IEPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define IEPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/iepd_pkg.sv
// types and constants of the intensity edge point detector
`timescale 1ns / 1ps

package iepd_pkg;

    typedef logic signed [23:0] t_coord;
    typedef logic [7:0]         t_refl;
    typedef logic [22:0]        t_range;
    typedef logic [3:0]         t_seen;

    // intensity taps held before a shift: the delayed point, two on each side, two newer
    localparam int INT_WIN = 7;
    // coordinate taps held before a shift: the oldest one is the delayed point
    localparam int POS_WIN = 5;
    // tap of the delayed point, counted before the shift
    localparam int CENTER  = 4;

    typedef t_refl t_int_win [0:INT_WIN-1];
    typedef t_coord t_pos_win [0:POS_WIN-1];

    // a line must have delivered this many points before the delayed point qualifies
    localparam t_seen SEEN_FULL = 4'd10;

    localparam t_range RANGE_RESET = 23'd50000;

    // dim ratio 0.4 as 5*min < 2*max, products fit in 11 bits
    localparam logic [10:0] DIM_LO_MUL = 11'd5;
    localparam logic [10:0] DIM_HI_MUL = 11'd2;

endpackage

### hw/rtl/iepd_edge_eval.sv
// edge feature decision for the delayed point of the window
`timescale 1ns / 1ps

module iepd_edge_eval (
    input  iepd_pkg::t_int_win i_int_win,
    input  iepd_pkg::t_coord   i_center_x,
    input  iepd_pkg::t_range   i_range,
    input  logic               i_seen_full,
    output logic               o_found
);
    import iepd_pkg::*;

    // 5*min < 2*max, fails when both are zero
    function automatic logic is_dim(input t_refl a, input t_refl b);
        t_refl hi;
        t_refl lo;
        begin
            hi = (a > b) ? a : b;
            lo = (a < b) ? a : b;
            return ({3'b000, lo} * DIM_LO_MUL) < ({3'b000, hi} * DIM_HI_MUL);
        end
    endfunction

    logic left_dim;
    logic right_dim;
    logic near;

    // lower taps are newer points, higher taps older ones
    assign left_dim  = is_dim(i_int_win[CENTER-1], i_int_win[CENTER]) &&
                       is_dim(i_int_win[CENTER-2], i_int_win[CENTER]);
    assign right_dim = is_dim(i_int_win[CENTER+1], i_int_win[CENTER]) &&
                       is_dim(i_int_win[CENTER+2], i_int_win[CENTER]);
    assign near      = i_center_x < $signed({1'b0, i_range});
    assign o_found   = i_seen_full && near && (left_dim || right_dim);

endmodule

### hw/rtl/intensity_edge_point_detector.sv
// top level of the intensity edge point detector
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_stall    point x, y, z, reflectivity, line_last
// out       source     o_out_valid / i_out_stall  found flag, delayed point, line_done
// cfg       sink       i_cfg_we                   max forward range, 23 bits
//
// one transaction in, one transaction out, held in the output register from
// the cycle after its point is taken; a new point is taken every cycle while
// the output moves; the answer describes the point five transactions back in
// the line (a cleared tap while fewer points are in); reset (synchronous, active low)
// clears the window, the line count and the output valid, and loads the range with 50000
// a stalled output holds the input off only while the output register is full

module intensity_edge_point_detector (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  iepd_pkg::t_range i_cfg_wdata,
    // input points
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  iepd_pkg::t_coord i_point_x_mm,
    input  iepd_pkg::t_coord i_point_y_mm,
    input  iepd_pkg::t_coord i_point_z_mm,
    input  iepd_pkg::t_refl  i_reflectivity,
    input  logic             i_line_last,
    // results
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_feature_found,
    output iepd_pkg::t_coord o_feature_x_mm,
    output iepd_pkg::t_coord o_feature_y_mm,
    output iepd_pkg::t_coord o_feature_z_mm,
    output iepd_pkg::t_refl  o_feature_reflectivity,
    output logic             o_line_done
);
    import iepd_pkg::*;

    // forward range limit
    t_range   r_range;

    // sliding window of the line, tap 0 is the newest point
    t_int_win r_int_win;
    t_pos_win r_x_win;
    t_pos_win r_y_win;
    t_pos_win r_z_win;
    t_seen    r_seen;

    // output register
    logic     r_out_valid;
    logic     r_found;
    t_coord   r_out_x;
    t_coord   r_out_y;
    t_coord   r_out_z;
    t_refl    r_out_refl;
    logic     r_out_done;

    logic     in_acc;
    logic     out_acc;
    logic     found;
    logic     seen_full;
    logic     n_out_valid;
    t_seen    n_seen;

    // the input waits only behind a full, stalled output register
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;

    // the delayed point is judged on the window as it stands before the shift
    assign seen_full = (r_seen >= SEEN_FULL);

    iepd_edge_eval u_eval (
        .i_int_win   (r_int_win),
        .i_center_x  (r_x_win[CENTER]),
        .i_range     (r_range),
        .i_seen_full (seen_full),
        .o_found     (found)
    );

    // saturating count of points taken in this line
    always_comb begin
        n_seen = seen_full ? r_seen : (r_seen + 4'd1);
    end

    always_comb begin
        if (in_acc) begin
            n_out_valid = 1'b1;
        end else if (out_acc) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // range register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RANGE_RESET;
        end else if (i_cfg_we) begin
            r_range <= i_cfg_wdata;
        end
    end

    // window shift, cleared at the end of a line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < INT_WIN; k++) begin
                r_int_win[k] <= '0;
            end
            for (int k = 0; k < POS_WIN; k++) begin
                r_x_win[k] <= '0;
                r_y_win[k] <= '0;
                r_z_win[k] <= '0;
            end
            r_seen <= '0;
        end else if (in_acc) begin
            if (i_line_last) begin
                for (int k = 0; k < INT_WIN; k++) begin
                    r_int_win[k] <= '0;
                end
                for (int k = 0; k < POS_WIN; k++) begin
                    r_x_win[k] <= '0;
                    r_y_win[k] <= '0;
                    r_z_win[k] <= '0;
                end
                r_seen <= '0;
            end else begin
                r_int_win[0] <= i_reflectivity;
                for (int k = 1; k < INT_WIN; k++) begin
                    r_int_win[k] <= r_int_win[k-1];
                end
                r_x_win[0] <= i_point_x_mm;
                r_y_win[0] <= i_point_y_mm;
                r_z_win[0] <= i_point_z_mm;
                for (int k = 1; k < POS_WIN; k++) begin
                    r_x_win[k] <= r_x_win[k-1];
                    r_y_win[k] <= r_y_win[k-1];
                    r_z_win[k] <= r_z_win[k-1];
                end
                r_seen <= n_seen;
            end
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload of the delayed point: the oldest coordinate taps, intensity tap CENTER
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_found    <= found;
            r_out_x    <= r_x_win[CENTER];
            r_out_y    <= r_y_win[CENTER];
            r_out_z    <= r_z_win[CENTER];
            r_out_refl <= r_int_win[CENTER];
            r_out_done <= i_line_last;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_feature_found        = r_found;
    assign o_feature_x_mm         = r_out_x;
    assign o_feature_y_mm         = r_out_y;
    assign o_feature_z_mm         = r_out_z;
    assign o_feature_reflectivity = r_out_refl;
    assign o_line_done            = r_out_done;

endmodule

### hw/rtl/iepd_checker.sv
// port-level assertions for the edge point detector and their bind
`timescale 1ns / 1ps
`include "intensity_edge_point_detector_defines.svh"

module iepd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             i_line_last,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_feature_found,
    input iepd_pkg::t_coord o_feature_x_mm,
    input iepd_pkg::t_coord o_feature_y_mm,
    input iepd_pkg::t_coord o_feature_z_mm,
    input iepd_pkg::t_refl  o_feature_reflectivity,
    input logic             o_line_done
);
    import iepd_pkg::*;

    logic        in_acc;
    logic        out_hold;
    logic        line_end;
    logic        done_ok;
    logic        win_clear;
    logic [82:0] out_word;
    logic        r_last_in;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_hold = o_out_valid && i_out_stall;
    assign line_end = in_acc && i_line_last;
    assign out_word = {o_out_valid, o_feature_found, o_feature_x_mm, o_feature_y_mm,
                       o_feature_z_mm, o_feature_reflectivity, o_line_done};

    // line end flag of the last offered point
    always_ff @(posedge i_clk) begin
        r_last_in <= i_line_last;
    end

    assign done_ok   = o_out_valid && (o_line_done == r_last_in);
    assign win_clear = !o_feature_found && (o_feature_x_mm == '0) &&
                       (o_feature_reflectivity == '0);

    // a stalled result stays put
    `IEPD_ASSERT_NEXT(a_out_hold, out_hold, $stable(out_word), "stalled result changed")

    // the input is held off only behind a full, stalled output
    `IEPD_ASSERT_NOW(a_stall_cause, o_in_stall, out_hold, "stall without a waiting result")

    // every accepted point yields a result next cycle carrying its line end
    `IEPD_ASSERT_NEXT(a_result_follows, in_acc, done_ok, "result missing")

    // the point right after a line end sees a cleared window
    `IEPD_ASSERT_NEXT(a_line_clear, line_end ##1 in_acc, win_clear, "window not cleared")

endmodule

bind intensity_edge_point_detector iepd_checker u_iepd_checker (.*);

### tb/iepd_scoreboard_pkg.sv
// transaction types and the scoreboard of the edge point detector bench
`timescale 1ns / 1ps

package iepd_scoreboard_pkg;

    import iepd_pkg::*;

    localparam int LAG       = 5;
    localparam int REFL_TAPS = 8;
    localparam int POS_TAPS  = 6;
    localparam int SHOW_MAX  = 10;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        t_refl  refl;
        logic   last;
    } point_t;

    typedef struct packed {
        logic   found;
        t_coord x;
        t_coord y;
        t_coord z;
        t_refl  refl;
        logic   done;
    } feature_t;

    class feature_scoreboard;
        t_range   range_mm;
        t_refl    refl_hist [0:REFL_TAPS-1];
        t_coord   x_hist [0:POS_TAPS-1];
        t_coord   y_hist [0:POS_TAPS-1];
        t_coord   z_hist [0:POS_TAPS-1];
        t_seen    seen;
        feature_t expected_q [$];
        int       errors;

        function void reset_state();
            range_mm = RANGE_RESET;
            clear_window();
            expected_q.delete();
            errors = 0;
        endfunction

        function void clear_window();
            for (int k = 0; k < REFL_TAPS; k++) refl_hist[k] = '0;
            for (int k = 0; k < POS_TAPS; k++) begin
                x_hist[k] = '0;
                y_hist[k] = '0;
                z_hist[k] = '0;
            end
            seen = '0;
        endfunction

        // ratio below 0.4, zero against zero fails
        function bit dim_pair(t_refl a, t_refl b);
            int hi;
            int lo;
            hi = (a > b) ? a : b;
            lo = (a < b) ? a : b;
            return (5 * lo) < (2 * hi);
        endfunction

        function void note_point(point_t p);
            feature_t want;
            t_refl    mid;
            bit       left_ok;
            bit       right_ok;
            bit       in_range;
            for (int k = REFL_TAPS - 1; k > 0; k--) refl_hist[k] = refl_hist[k-1];
            refl_hist[0] = p.refl;
            for (int k = POS_TAPS - 1; k > 0; k--) begin
                x_hist[k] = x_hist[k-1];
                y_hist[k] = y_hist[k-1];
                z_hist[k] = z_hist[k-1];
            end
            x_hist[0] = p.x;
            y_hist[0] = p.y;
            z_hist[0] = p.z;
            want.found = 1'b0;
            if (seen >= SEEN_FULL) begin
                mid      = refl_hist[LAG];
                left_ok  = dim_pair(refl_hist[LAG-1], mid) && dim_pair(refl_hist[LAG-2], mid);
                right_ok = dim_pair(refl_hist[LAG+1], mid) && dim_pair(refl_hist[LAG+2], mid);
                in_range = int'(x_hist[LAG]) < int'(range_mm);
                want.found = (left_ok || right_ok) && in_range;
            end
            if (seen < SEEN_FULL) seen++;
            want.x    = x_hist[LAG];
            want.y    = y_hist[LAG];
            want.z    = z_hist[LAG];
            want.refl = refl_hist[LAG];
            want.done = p.last;
            expected_q = {expected_q, want};
            if (p.last) clear_window();
        endfunction

        function void check_result(feature_t got);
            feature_t want;
            string    bad;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("result with no transaction waiting: found=%0b x=%0d refl=%0d",
                             got.found, got.x, got.refl);
                return;
            end
            want = expected_q.pop_front();
            bad  = "";
            if (got.found !== want.found) bad = {bad, " found"};
            if (got.x !== want.x)         bad = {bad, " x"};
            if (got.y !== want.y)         bad = {bad, " y"};
            if (got.z !== want.z)         bad = {bad, " z"};
            if (got.refl !== want.refl)   bad = {bad, " refl"};
            if (got.done !== want.done)   bad = {bad, " done"};
            if (bad != "") begin
                errors++;
                if (errors <= SHOW_MAX) begin
                    $display("mismatch in%s: expected found=%0b x=%0d y=%0d z=%0d refl=%0d done=%0b",
                             bad, want.found, want.x, want.y, want.z, want.refl, want.done);
                    $display("    got found=%0b x=%0d y=%0d z=%0d refl=%0d done=%0b",
                             got.found, got.x, got.y, got.z, got.refl, got.done);
                end
            end
        endfunction
    endclass

endpackage

### tb/tb.sv
// bench top of the intensity edge point detector
`timescale 1ns / 1ps

module tb;

    import iepd_pkg::*;
    import iepd_scoreboard_pkg::*;

    // stretch of receiver hold-off that lets the block fill and stall its input
    localparam int HOLD_CYCLES = 64;
    // cycles with no transaction on either side before the run is abandoned
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 4;

    logic   i_clk          = 1'b0;
    logic   i_rst_n        = 1'b0;
    logic   i_cfg_we       = 1'b0;
    t_range i_cfg_wdata    = '0;
    logic   i_in_valid     = 1'b0;
    t_coord i_point_x_mm   = '0;
    t_coord i_point_y_mm   = '0;
    t_coord i_point_z_mm   = '0;
    t_refl  i_reflectivity = '0;
    logic   i_line_last    = 1'b0;
    logic   i_out_stall    = 1'b0;

    logic   o_in_stall;
    logic   o_out_valid;
    logic   o_feature_found;
    t_coord o_feature_x_mm;
    t_coord o_feature_y_mm;
    t_coord o_feature_z_mm;
    t_refl  o_feature_reflectivity;
    logic   o_line_done;

    feature_scoreboard sb;

    // idle rates in percent for each side, changed between phases
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // hold-off requests from the main sequence, served by the stall process
    int hold_reqs   = 0;
    int hold_served = 0;
    int quiet_cycles = 0;

    intensity_edge_point_detector i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_point_x_mm           (i_point_x_mm),
        .i_point_y_mm           (i_point_y_mm),
        .i_point_z_mm           (i_point_z_mm),
        .i_reflectivity         (i_reflectivity),
        .i_line_last            (i_line_last),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_feature_found        (o_feature_found),
        .o_feature_x_mm         (o_feature_x_mm),
        .o_feature_y_mm         (o_feature_y_mm),
        .o_feature_z_mm         (o_feature_z_mm),
        .o_feature_reflectivity (o_feature_reflectivity),
        .o_line_done            (o_line_done)
    );

    // 2 ns clock, first rising edge at 1 ns
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver side: random stall, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_served) begin
                hold_served++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // result monitor: every output transaction goes to the scoreboard
    always @(posedge i_clk) begin : result_monitor
        feature_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_feature_found, o_feature_x_mm, o_feature_y_mm, o_feature_z_mm,
                   o_feature_reflectivity, o_line_done};
            sb.check_result(got);
        end
    end

    // watchdog: abandon the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic point_t make_point(input int x, input int y, input int z,
                                          input int refl, input logic last);
        point_t p;
        p.x    = t_coord'(x);
        p.y    = t_coord'(y);
        p.z    = t_coord'(z);
        p.refl = t_refl'(refl);
        p.last = last;
        return p;
    endfunction

    // random point; x is often placed around the range limit or below zero,
    // intensities lean toward dark and bright so the dim test goes both ways
    function automatic point_t random_point(input logic last);
        point_t p;
        int     xv;
        int     rv;
        case ($urandom_range(3))
            0: xv = $urandom();
            1: xv = int'(sb.range_mm) + $urandom_range(64) - 32;
            2: xv = -$urandom_range(1, 100000);
            default: xv = $urandom_range(100000);
        endcase
        case ($urandom_range(4))
            0: rv = 0;
            1: rv = $urandom_range(15);
            2: rv = $urandom_range(180, 255);
            default: rv = $urandom_range(255);
        endcase
        p = make_point(xv, $urandom(), $urandom(), rv, last);
        return p;
    endfunction

    // offer one point, with random idle cycles ahead of it, and hold it until taken
    task automatic send_point(input point_t p);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_point_x_mm   <= p.x;
        i_point_y_mm   <= p.y;
        i_point_z_mm   <= p.z;
        i_reflectivity <= p.refl;
        i_line_last    <= p.last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_point(p);
    endtask

    // stop offering and let every expected result come out
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // only called while the block is empty
    task automatic write_range(input t_range value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.range_mm  = value;
    endtask

    // whole scan lines of random length; most are long enough to hold features,
    // some are short lines that never can
    task automatic run_lines(input int n_items);
        int sent;
        int line_len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0, 1: line_len = $urandom_range(1, 10);
                2:    line_len = $urandom_range(31, 60);
                default: line_len = $urandom_range(11, 30);
            endcase
            for (int k = 0; k < line_len; k++) begin
                send_point(random_point(k == line_len - 1));
                sent++;
            end
        end
    endtask

    initial begin
        sb = new;
        sb.reset_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, range still at its reset value
        // line of twelve: coordinate and intensity extremes, a feature with dim
        // points on its left, then one that is dim against its bright right
        // neighbours at the most negative x
        send_point(make_point( 8388607, -8388608,  8388607,   0, 1'b0));
        send_point(make_point(-8388608,  8388607, -8388608, 255, 1'b0));
        send_point(make_point(       0,        0,        0,   0, 1'b0));
        send_point(make_point(      -1,       -1,       -1,   0, 1'b0));
        send_point(make_point(   12345,        2,        3, 255, 1'b0));
        send_point(make_point(    1000,     -500,       42, 200, 1'b0));
        send_point(make_point(-8388608,       77,      -77,  10, 1'b0));
        send_point(make_point(   49999,        1,        1,  10, 1'b0));
        send_point(make_point(   60000,        5,        6, 255, 1'b0));
        send_point(make_point(       0,        7,        8, 255, 1'b0));
        send_point(make_point(       0,        9,       10,   0, 1'b0));
        send_point(make_point(       0,       11,       12,   0, 1'b1));
        // line of eleven: dim, zero-intensity neighbours on its left, but x sits exactly
        // at the range limit
        send_point(make_point(     100,      100,      100,   0, 1'b0));
        send_point(make_point(     200,      200,      200,   0, 1'b0));
        send_point(make_point(     300,      300,      300,   0, 1'b0));
        send_point(make_point(     400,      400,      400, 100, 1'b0));
        send_point(make_point(     500,      500,      500, 100, 1'b0));
        send_point(make_point(   50000,      600,      600, 100, 1'b0));
        send_point(make_point(     700,      700,      700,   0, 1'b0));
        send_point(make_point(     800,      800,      800,   0, 1'b0));
        send_point(make_point(     900,      900,      900,   5, 1'b0));
        send_point(make_point(    1000,     1000,     1000,   5, 1'b0));
        send_point(make_point(    1100,     1100,     1100,   5, 1'b1));
        // two-point line: nothing leaves the window, zeros come out
        send_point(make_point(     -10,      -20,      -30,   0, 1'b0));
        send_point(make_point(     -40,      -50,      -60,   0, 1'b1));
        wait_for_results();

        // widest range, receiver stalls often
        write_range(23'h7FFFFF);
        tx_idle_pct = 8;
        rx_idle_pct = 58;
        run_lines(280);
        wait_for_results();

        // zero range: only points behind the sensor qualify; sender idles often
        write_range('0);
        tx_idle_pct = 58;
        rx_idle_pct = 8;
        run_lines(280);
        wait_for_results();

        // no idling; a long receiver hold-off while points keep being offered
        write_range(t_range'($urandom_range(1000, 100000)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_reqs++;
        run_lines(60);
        wait_for_results();

        write_range(RANGE_RESET);
        run_lines(230);
        wait_for_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
